### src/assert_macros.svh
// Assertion macros shared by the RTL of the plus/minus/paren evaluator.
// Expects signals clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When cond holds at an edge, prop holds at the next edge.
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

### src/pmpe_pkg.sv
// Shared types and constants of the plus/minus/paren evaluator.
// No dependencies.
`default_nettype none

package pmpe_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int OUT_WIDTH       = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DIGIT,
    OP_PLUS,
    OP_MINUS,
    OP_OPEN,
    OP_CLOSE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] digit;
    logic       last;
  } item_t;

endpackage

`default_nettype wire

### src/pmpe_front.sv
// Front stage: accepts characters and registers their decoded operation.
// Depends on pmpe_pkg.
`default_nettype none

module pmpe_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     in_char_code,
  input  wire logic           in_last_char,
  output logic                fr_valid,
  input  wire logic           fr_ready,
  output pmpe_pkg::item_t     fr_item
);

  logic            valid_r;
  pmpe_pkg::item_t item_r;
  pmpe_pkg::item_t item_nxt;
  logic [7:0]      digit_full;

  assign in_ready = !valid_r || fr_ready;
  assign fr_valid = valid_r;
  assign fr_item  = item_r;

  always_comb begin
    digit_full     = in_char_code - pmpe_pkg::CH_ZERO;
    item_nxt.digit = digit_full[3:0];
    item_nxt.last  = in_last_char;
    if (in_char_code >= pmpe_pkg::CH_ZERO && in_char_code <= pmpe_pkg::CH_NINE) begin
      item_nxt.op = pmpe_pkg::OP_DIGIT;
    end else if (in_char_code == pmpe_pkg::CH_PLUS) begin
      item_nxt.op = pmpe_pkg::OP_PLUS;
    end else if (in_char_code == pmpe_pkg::CH_MINUS) begin
      item_nxt.op = pmpe_pkg::OP_MINUS;
    end else if (in_char_code == pmpe_pkg::CH_OPEN) begin
      item_nxt.op = pmpe_pkg::OP_OPEN;
    end else if (in_char_code == pmpe_pkg::CH_CLOSE) begin
      item_nxt.op = pmpe_pkg::OP_CLOSE;
    end else begin
      item_nxt.op = pmpe_pkg::OP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

### src/pmpe_queue.sv
// Small FIFO of decoded operations between front and back stages.
// Depends on pmpe_pkg.
`default_nettype none

module pmpe_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_in_valid,
  output logic                 q_in_ready,
  input  wire pmpe_pkg::item_t q_in_item,
  output logic                 q_out_valid,
  input  wire logic            q_out_ready,
  output pmpe_pkg::item_t      q_out_item
);

  pmpe_pkg::item_t                  slot_r [pmpe_pkg::QUEUE_DEPTH];
  logic [pmpe_pkg::QUEUE_AW-1:0]    wr_ptr_r;
  logic [pmpe_pkg::QUEUE_AW-1:0]    rd_ptr_r;
  logic [pmpe_pkg::QUEUE_CW-1:0]    count_r;
  logic                             push;
  logic                             pop;

  assign q_in_ready  = count_r != pmpe_pkg::QUEUE_CW'(pmpe_pkg::QUEUE_DEPTH);
  assign q_out_valid = count_r != '0;
  assign q_out_item  = slot_r[rd_ptr_r];
  assign push        = q_in_valid && q_in_ready;
  assign pop         = q_out_valid && q_out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
    if (push) begin
      slot_r[wr_ptr_r] <= q_in_item;
    end
  end

endmodule

`default_nettype wire

### src/pmpe_back.sv
// Back stage: running sum, sign, partial number, context stack and result register.
// Depends on pmpe_pkg.
`default_nettype none

module pmpe_back #(
  parameter int STACK_DEPTH = pmpe_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = pmpe_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              bk_valid,
  output logic                                   bk_ready,
  input  wire pmpe_pkg::item_t                   bk_item,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [pmpe_pkg::OUT_WIDTH-1:0]  out_value,
  output logic [1:0]                             out_status
);

  localparam int VW = VALUE_WIDTH;
  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int OW = pmpe_pkg::OUT_WIDTH;

  logic [VW:0]    stack_mem [STACK_DEPTH];
  logic [VW:0]    below_r;
  logic [VW:0]    tos_r, tos_nxt;
  logic [VW-1:0]  sum_r, sum_nxt;
  logic           neg_r, neg_nxt;
  logic [VW-1:0]  part_r, part_nxt;
  logic [LW-1:0]  level_r, level_nxt;
  logic [1:0]     err_r, err_nxt;
  logic [1:0]     err_fin;
  logic           out_valid_r;
  logic [OW-1:0]  out_value_r;
  logic [1:0]     out_status_r;
  logic           fire;
  logic           push;
  logic [VW-1:0]  inner;
  logic [VW-1:0]  outer_sum;
  logic           outer_neg;
  logic [VW-1:0]  final_sum;
  logic [VW+OW-1:0] final_ext;
  logic [LW-1:0]  rd_full;
  logic [AW-1:0]  rd_addr;

  assign bk_ready   = !out_valid_r || out_ready;
  assign fire       = bk_valid && bk_ready;
  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  always_comb begin
    sum_nxt   = sum_r;
    neg_nxt   = neg_r;
    part_nxt  = part_r;
    level_nxt = level_r;
    err_nxt   = err_r;
    err_fin   = err_r;
    tos_nxt   = tos_r;
    push      = 1'b0;
    inner     = neg_r ? sum_r - part_r : sum_r + part_r;
    outer_sum = '0;
    outer_neg = 1'b0;
    final_sum = '0;
    if (fire) begin
      case (bk_item.op)
        pmpe_pkg::OP_DIGIT: begin
          part_nxt = (part_r << 3) + (part_r << 1) + {{(VW-4){1'b0}}, bk_item.digit};
        end
        pmpe_pkg::OP_PLUS, pmpe_pkg::OP_MINUS: begin
          sum_nxt  = inner;
          part_nxt = '0;
          neg_nxt  = bk_item.op == pmpe_pkg::OP_MINUS;
        end
        pmpe_pkg::OP_OPEN: begin
          if (level_r < LW'(STACK_DEPTH)) begin
            push      = 1'b1;
            tos_nxt   = {neg_r, sum_r};
            level_nxt = level_r + 1'b1;
          end else if (err_r == pmpe_pkg::ST_OK) begin
            err_nxt = pmpe_pkg::ST_OVERFLOW;
          end
          sum_nxt = '0;
          neg_nxt = 1'b0;
        end
        pmpe_pkg::OP_CLOSE: begin
          part_nxt = '0;
          if (level_r != '0) begin
            outer_sum = tos_r[VW-1:0];
            outer_neg = tos_r[VW];
            level_nxt = level_r - 1'b1;
            tos_nxt   = below_r;
          end else if (err_r == pmpe_pkg::ST_OK) begin
            err_nxt = pmpe_pkg::ST_UNDERFLOW;
          end
          sum_nxt = outer_neg ? outer_sum - inner : outer_sum + inner;
          neg_nxt = 1'b0;
        end
        default: begin
        end
      endcase
      // fold whatever partial number is left after this character
      final_sum = neg_nxt ? sum_nxt - part_nxt : sum_nxt + part_nxt;
      err_fin   = err_nxt;
      if (bk_item.last) begin
        sum_nxt   = '0;
        neg_nxt   = 1'b0;
        part_nxt  = '0;
        level_nxt = '0;
        err_nxt   = pmpe_pkg::ST_OK;
      end
    end
    final_ext = {{OW{1'b0}}, final_sum};
    rd_full   = level_nxt - LW'(2);
    rd_addr   = rd_full[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      neg_r       <= 1'b0;
      part_r      <= '0;
      level_r     <= '0;
      err_r       <= pmpe_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      sum_r   <= sum_nxt;
      neg_r   <= neg_nxt;
      part_r  <= part_nxt;
      level_r <= level_nxt;
      err_r   <= err_nxt;
      if (fire && bk_item.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    tos_r <= tos_nxt;
    if (fire && bk_item.last) begin
      out_value_r  <= final_ext[OW-1:0];
      out_status_r <= err_fin;
    end
  end

  // top of stack lives in tos_r; below_r prefetches the entry under it
  always_ff @(posedge clk) begin
    if (push) begin
      stack_mem[level_r[AW-1:0]] <= tos_nxt;
    end
    below_r <= stack_mem[rd_addr];
  end

endmodule

`default_nettype wire

### src/plus_minus_paren_evaluator.sv
// Top level of the plus/minus/paren expression evaluator.
// Depends on pmpe_pkg, pmpe_front, pmpe_queue, pmpe_back and assert_macros.svh.
//
// One ASCII character is taken per transfer and up to one character per clock
// is sustained; with no stalls the result of an expression passes through the
// front register, the queue and the back stage into an output register, is held
// there until taken, and a result left waiting stalls the back stage. The rate is set
// by the back stage, which folds numbers and pushes or pops the nesting stack
// for each character it takes: the top of stack is kept in a register and the entry under
// it is prefetched from the stack memory, so back-to-back closing parentheses
// do not stall it. Arithmetic wraps at VALUE_WIDTH bits; status is 0 for
// ok, 1 for nesting overflow and 2 for an unmatched closing parenthesis.
`default_nettype none
`include "assert_macros.svh"

module plus_minus_paren_evaluator #(
  parameter int STACK_DEPTH = pmpe_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = pmpe_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [7:0]                       in_char_code,
  input  wire logic                             in_last_char,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [pmpe_pkg::OUT_WIDTH-1:0] out_value,
  output logic [1:0]                            out_status
);

  logic            fr_valid;
  logic            fr_ready;
  pmpe_pkg::item_t fr_item;
  logic            bk_valid;
  logic            bk_ready;
  pmpe_pkg::item_t bk_item;

  pmpe_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .in_last_char (in_last_char),
    .fr_valid     (fr_valid),
    .fr_ready     (fr_ready),
    .fr_item      (fr_item)
  );

  pmpe_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_in_valid  (fr_valid),
    .q_in_ready  (fr_ready),
    .q_in_item   (fr_item),
    .q_out_valid (bk_valid),
    .q_out_ready (bk_ready),
    .q_out_item  (bk_item)
  );

  pmpe_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .bk_valid   (bk_valid),
    .bk_ready   (bk_ready),
    .bk_item    (bk_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .out_status (out_status)
  );

  `ASSERT_ALWAYS(a_status_code, !out_valid || out_status != 2'd3, "invalid status code")
  `ASSERT_ALWAYS(a_front_holds, in_ready || fr_valid, "input stalled with empty front stage")
  `ASSERT_NEXT(a_front_kept, fr_valid && !fr_ready, fr_valid && $stable(fr_item), "item lost")
  `ASSERT_NEXT(a_result_kept, out_valid && !out_ready, out_valid && $stable(out_value), "result lost")

endmodule

`default_nettype wire
